// ----- hw/rtl/hue_mask_cross_dilate_unit_assert.svh -----
// Assertion macros for the hue mask cross dilation block.
// Define ASSERT_OFF to compile every check away.
`ifndef HUE_MASK_CROSS_DILATE_UNIT_ASSERT_SVH
`define HUE_MASK_CROSS_DILATE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define HMCD_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("hmcd: same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define HMCD_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("hmcd: next-cycle check failed");
`else
`define HMCD_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define HMCD_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ----- hw/rtl/hmcd_pkg.sv -----
`default_nettype none
package hmcd_pkg;

    // Field and register widths.
    localparam int POS_W      = 21;
    localparam int WID_W      = 11;
    localparam int RAD_W      = 5;
    localparam int HUE_W      = 8;
    localparam int CH_W       = 8;
    localparam int COL_W      = 3 * CH_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // Defaults for the top-level parameters, and the fixed height limit.
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_RADIUS_DEF = 20;
    localparam int MAX_HEIGHT     = 1024;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HUE_LOW      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HUE_HIGH     = 3'd4;

    // Register reset values.
    localparam logic [WID_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [WID_W-1:0] FRAME_HEIGHT_RST = 11'd480;
    localparam logic [RAD_W-1:0] RADIUS_RST       = 5'd0;
    localparam logic [HUE_W-1:0] HUE_LOW_RST      = 8'd0;
    localparam logic [HUE_W-1:0] HUE_HIGH_RST     = 8'd20;

    // Item kinds.
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    // Colour of a pixel that is not kept.
    localparam logic [COL_W-1:0] COL_WHITE = {COL_W{1'b1}};

    // Clamped and precomputed configuration.
    typedef struct packed {
        logic [WID_W-1:0] width;
        logic [POS_W-1:0] total;
        logic [POS_W-1:0] rw;
        logic [RAD_W-1:0] radius;
        logic [HUE_W-1:0] hue_low;
        logic [HUE_W-1:0] hue_high;
    } hmcd_cfg_t;

    // One neighbour lookup for the shared address unit.
    typedef struct packed {
        logic             minus;
        logic [POS_W-1:0] off;
    } hmcd_nbr_req_t;

    // Memory controls from the sequencer to the stores.
    typedef struct packed {
        logic             hit_we;
        logic             hit_bit;
        logic [POS_W-1:0] hit_waddr;
        logic [POS_W-1:0] hit_raddr;
        logic             edge_we;
        logic [POS_W-1:0] edge_waddr;
        logic [COL_W-1:0] edge_wdata;
        logic [POS_W-1:0] edge_raddr;
    } hmcd_mem_req_t;

endpackage
`default_nettype wire

// ----- hw/rtl/hmcd_in_if.sv -----
`default_nettype none
interface hmcd_in_if;
    import hmcd_pkg::*;

    logic             valid;
    logic             ready;
    logic             func;
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  edge_blue;
    logic [CH_W-1:0]  edge_green;
    logic [CH_W-1:0]  edge_red;

    modport source (output valid, func, hue, edge_blue, edge_green, edge_red, input ready);
    modport sink   (input valid, func, hue, edge_blue, edge_green, edge_red, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/hmcd_out_if.sv -----
`default_nettype none
interface hmcd_out_if;
    import hmcd_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_red;
    logic            out_kept;
    logic            out_last;

    modport source (output valid, out_blue, out_green, out_red, out_kept, out_last,
                    input ready);
    modport sink   (input valid, out_blue, out_green, out_red, out_kept, out_last,
                    output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/hmcd_cfg_regs.sv -----
`default_nettype none
module hmcd_cfg_regs #(
    parameter int MAX_WIDTH  = hmcd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = hmcd_pkg::MAX_RADIUS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [hmcd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hmcd_pkg::CFG_DATA_W-1:0] cfg_data,
    output hmcd_pkg::hmcd_cfg_t                  cfg
);
    import hmcd_pkg::*;

    logic [WID_W-1:0]     width_reg;
    logic [WID_W-1:0]     height_reg;
    logic [RAD_W-1:0]     radius_reg;
    logic [HUE_W-1:0]     hue_low_reg;
    logic [HUE_W-1:0]     hue_high_reg;
    logic [WID_W-1:0]     w_eff;
    logic [WID_W-1:0]     h_eff;
    logic [RAD_W-1:0]     r_eff;
    logic [2*WID_W-1:0]   total_full;
    logic [WID_W+RAD_W-1:0] rw_full;
    hmcd_cfg_t            cfg_next;
    hmcd_cfg_t            cfg_reg;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= FRAME_WIDTH_RST;
            height_reg   <= FRAME_HEIGHT_RST;
            radius_reg   <= RADIUS_RST;
            hue_low_reg  <= HUE_LOW_RST;
            hue_high_reg <= HUE_HIGH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  width_reg    <= cfg_data[WID_W-1:0];
                REG_FRAME_HEIGHT: height_reg   <= cfg_data[WID_W-1:0];
                REG_RADIUS:       radius_reg   <= cfg_data[RAD_W-1:0];
                REG_HUE_LOW:      hue_low_reg  <= cfg_data[HUE_W-1:0];
                REG_HUE_HIGH:     hue_high_reg <= cfg_data[HUE_W-1:0];
                default:          ;
            endcase
        end
    end

    // Clamp the geometry and form the frame size and the look-ahead span.
    always_comb
    begin
        if (width_reg == '0)
            w_eff = WID_W'(1);
        else if (POS_W'(width_reg) > POS_W'(MAX_WIDTH))
            w_eff = WID_W'(MAX_WIDTH);
        else
            w_eff = width_reg;

        if (height_reg == '0)
            h_eff = WID_W'(1);
        else if (POS_W'(height_reg) > POS_W'(MAX_HEIGHT))
            h_eff = WID_W'(MAX_HEIGHT);
        else
            h_eff = height_reg;

        if (POS_W'(radius_reg) > POS_W'(MAX_RADIUS))
            r_eff = RAD_W'(MAX_RADIUS);
        else
            r_eff = radius_reg;

        total_full = (2*WID_W)'(w_eff) * (2*WID_W)'(h_eff);
        rw_full    = (WID_W+RAD_W)'(r_eff) * (WID_W+RAD_W)'(w_eff);

        cfg_next.width    = w_eff;
        cfg_next.total    = total_full[POS_W-1:0];
        cfg_next.rw       = POS_W'(rw_full);
        cfg_next.radius   = r_eff;
        cfg_next.hue_low  = hue_low_reg;
        cfg_next.hue_high = hue_high_reg;
    end

    // The products are registered before anyone uses them.
    always_ff @(posedge clk)
    begin
        cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/hmcd_stores.sv -----
`default_nettype none
module hmcd_stores #(
    parameter int HIT_DEPTH  = 2 * hmcd_pkg::MAX_RADIUS_DEF * hmcd_pkg::MAX_WIDTH_DEF + 1,
    parameter int EDGE_DEPTH = hmcd_pkg::MAX_RADIUS_DEF * hmcd_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                        clk,
    input  hmcd_pkg::hmcd_mem_req_t          mem_req,
    output logic                             hit_rd,
    output logic [hmcd_pkg::COL_W-1:0]       edge_rd
);
    import hmcd_pkg::*;

    localparam int HA_W = $clog2(HIT_DEPTH);
    localparam int EA_W = $clog2(EDGE_DEPTH);

    logic             hit_mem [HIT_DEPTH];
    logic [COL_W-1:0] edge_mem [EDGE_DEPTH];
    logic             hit_rd_reg;
    logic [COL_W-1:0] edge_rd_reg;

    // In-band bit store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_req.hit_we)
            hit_mem[mem_req.hit_waddr[HA_W-1:0]] <= mem_req.hit_bit;
        hit_rd_reg <= hit_mem[mem_req.hit_raddr[HA_W-1:0]];
    end

    // Delayed colour store: the read returns the old entry on a same-address write.
    always_ff @(posedge clk)
    begin
        if (mem_req.edge_we)
            edge_mem[mem_req.edge_waddr[EA_W-1:0]] <= mem_req.edge_wdata;
        edge_rd_reg <= edge_mem[mem_req.edge_raddr[EA_W-1:0]];
    end

    assign hit_rd  = hit_rd_reg;
    assign edge_rd = edge_rd_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/hmcd_nbr_unit.sv -----
`default_nettype none
module hmcd_nbr_unit #(
    parameter int HIT_DEPTH = 2 * hmcd_pkg::MAX_RADIUS_DEF * hmcd_pkg::MAX_WIDTH_DEF + 1
) (
    input  wire logic [hmcd_pkg::POS_W-1:0] pos,
    input  wire logic [hmcd_pkg::POS_W-1:0] lim,
    input  wire logic [hmcd_pkg::POS_W-1:0] base,
    input  hmcd_pkg::hmcd_nbr_req_t         req,
    output logic                            ok,
    output logic [hmcd_pkg::POS_W-1:0]      addr
);
    import hmcd_pkg::*;

    localparam logic [POS_W:0] DEPTH = (POS_W+1)'(HIT_DEPTH);

    logic [POS_W:0] pos_sum;
    logic [POS_W:0] base_sum;
    logic [POS_W:0] base_dif;
    logic [POS_W:0] addr_w;

    // Bounds check against the frame and circular address of the neighbour.
    always_comb
    begin
        pos_sum  = {1'b0, pos} + {1'b0, req.off};
        base_sum = {1'b0, base} + {1'b0, req.off};
        base_dif = {1'b0, base} - {1'b0, req.off};
        if (req.minus)
        begin
            ok     = pos >= req.off;
            addr_w = (base >= req.off) ? base_dif : base_dif + DEPTH;
        end
        else
        begin
            ok     = pos_sum < {1'b0, lim};
            addr_w = (base_sum >= DEPTH) ? base_sum - DEPTH : base_sum;
        end
        addr = addr_w[POS_W-1:0];
    end

endmodule
`default_nettype wire

// ----- hw/rtl/hmcd_seq.sv -----
`default_nettype none
`include "hue_mask_cross_dilate_unit_assert.svh"
module hmcd_seq #(
    parameter int HIT_DEPTH  = 2 * hmcd_pkg::MAX_RADIUS_DEF * hmcd_pkg::MAX_WIDTH_DEF + 1,
    parameter int EDGE_DEPTH = hmcd_pkg::MAX_RADIUS_DEF * hmcd_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    hmcd_in_if.sink                      pix_in,
    hmcd_out_if.source                   pix_out,
    input  hmcd_pkg::hmcd_cfg_t          cfg,
    output hmcd_pkg::hmcd_mem_req_t      mem_req,
    input  wire logic                    hit_rd,
    input  wire logic [hmcd_pkg::COL_W-1:0] edge_rd
);
    import hmcd_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_STORE = 3'd1;
    localparam logic [2:0] S_GO    = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_TAIL  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    localparam logic [POS_W-1:0] HIT_LAST  = POS_W'(HIT_DEPTH - 1);
    localparam logic [POS_W-1:0] EDGE_LAST = POS_W'(EDGE_DEPTH - 1);

    // Control state.
    logic [2:0]       state_reg, state_next;
    logic [POS_W-1:0] in_pos_reg, in_pos_next;
    logic [POS_W-1:0] out_pos_reg, out_pos_next;
    logic [POS_W-1:0] in_haddr_reg, in_haddr_next;
    logic [POS_W-1:0] out_haddr_reg, out_haddr_next;
    logic [POS_W-1:0] in_eaddr_reg, in_eaddr_next;
    logic [POS_W-1:0] out_eaddr_reg, out_eaddr_next;
    logic             chk_vld_reg, chk_vld_next;
    logic             out_valid_reg, out_valid_next;

    // Payload and scan working registers.
    logic             func_reg, func_next;
    logic [HUE_W-1:0] hue_reg, hue_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic             own_reg, own_next;
    logic [COL_W-1:0] colour_reg, colour_next;
    logic [POS_W-1:0] lim_reg, lim_next;
    logic             first_reg, first_next;
    logic [RAD_W-1:0] d_reg, d_next;
    logic [1:0]       sub_reg, sub_next;
    logic [POS_W-1:0] dw_reg, dw_next;
    logic             kept_reg, kept_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic             out_kept_reg, out_kept_next;
    logic             out_last_reg, out_last_next;

    logic             in_fire;
    logic             emit_load;
    logic             go;
    logic             in_band;
    logic             last_pix;
    logic [POS_W:0]   out_pos_inc;
    hmcd_nbr_req_t    nbr_req;
    logic             nbr_ok;
    logic [POS_W-1:0] nbr_addr;

    // Shared neighbour address and bounds unit.
    hmcd_nbr_unit #(
        .HIT_DEPTH (HIT_DEPTH)
    ) u_nbr (
        .pos  (out_pos_reg),
        .lim  (lim_reg),
        .base (out_haddr_reg),
        .req  (nbr_req),
        .ok   (nbr_ok),
        .addr (nbr_addr)
    );

    assign pix_in.ready = (state_reg == S_IDLE);
    assign in_fire      = pix_in.valid && (state_reg == S_IDLE);
    assign emit_load    = (state_reg == S_EMIT) && (!out_valid_reg || pix_out.ready);
    assign in_band      = (hue_reg >= cfg.hue_low) && (hue_reg <= cfg.hue_high);
    assign out_pos_inc  = {1'b0, out_pos_reg} + (POS_W+1)'(1);
    assign last_pix     = out_pos_inc >= {1'b0, cfg.total};

    // Emission test for a pixel item: all needed neighbours are in, or the frame is.
    assign go = (func_reg == FUNC_FLUSH)
             || ((out_pos_reg < in_pos_reg)
                 && ((({1'b0, out_pos_reg} + {1'b0, cfg.rw}) < {1'b0, in_pos_reg})
                     || (in_pos_reg >= cfg.total)));

    // Neighbour order per distance: p-d, p+d, p-dW, p+dW; the pixel itself comes first.
    // The pixel itself is looked up as a zero backward step, which is never out of bounds.
    always_comb
    begin
        nbr_req.minus = first_reg || !sub_reg[0];
        if (first_reg)
            nbr_req.off = '0;
        else if (sub_reg[1])
            nbr_req.off = dw_reg;
        else
            nbr_req.off = POS_W'(d_reg);
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        in_pos_next    = in_pos_reg;
        out_pos_next   = out_pos_reg;
        in_haddr_next  = in_haddr_reg;
        out_haddr_next = out_haddr_reg;
        in_eaddr_next  = in_eaddr_reg;
        out_eaddr_next = out_eaddr_reg;
        chk_vld_next   = 1'b0;
        out_valid_next = out_valid_reg && !pix_out.ready;
        func_next      = func_reg;
        hue_next       = hue_reg;
        col_next       = col_reg;
        own_next       = own_reg;
        colour_next    = colour_reg;
        lim_next       = lim_reg;
        first_next     = first_reg;
        d_next         = d_reg;
        sub_next       = sub_reg;
        dw_next        = dw_reg;
        kept_next      = kept_reg || (chk_vld_reg && hit_rd);
        out_col_next   = out_col_reg;
        out_kept_next  = out_kept_reg;
        out_last_next  = out_last_reg;

        mem_req.hit_we     = 1'b0;
        mem_req.hit_bit    = in_band;
        mem_req.hit_waddr  = in_haddr_reg;
        mem_req.hit_raddr  = nbr_addr;
        mem_req.edge_we    = 1'b0;
        mem_req.edge_waddr = in_eaddr_reg;
        mem_req.edge_wdata = col_reg;
        mem_req.edge_raddr = out_eaddr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    func_next  = pix_in.func;
                    hue_next   = pix_in.hue;
                    col_next   = {pix_in.edge_red, pix_in.edge_green, pix_in.edge_blue};
                    state_next = S_STORE;
                end
            end

            // Store or drop a pixel, or check that a flush has something to drain.
            S_STORE:
            begin
                own_next = 1'b0;
                if (func_reg == FUNC_FLUSH)
                begin
                    state_next = (out_pos_reg < in_pos_reg) ? S_GO : S_IDLE;
                end
                else if (in_pos_reg >= cfg.total)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_req.hit_we  = 1'b1;
                    mem_req.edge_we = 1'b1;
                    own_next        = (out_pos_reg == in_pos_reg);
                    in_pos_next     = in_pos_reg + POS_W'(1);
                    in_haddr_next   = (in_haddr_reg == HIT_LAST) ? '0
                                    : in_haddr_reg + POS_W'(1);
                    in_eaddr_next   = (in_eaddr_reg == EDGE_LAST) ? '0
                                    : in_eaddr_reg + POS_W'(1);
                    state_next      = S_GO;
                end
            end

            // Decide on emission and set up the scan.
            S_GO:
            begin
                colour_next = own_reg ? col_reg : edge_rd;
                lim_next    = (in_pos_reg < cfg.total) ? in_pos_reg : cfg.total;
                first_next  = 1'b1;
                kept_next   = 1'b0;
                state_next  = go ? S_SCAN : S_IDLE;
            end

            // One neighbour read per cycle through the shared unit.
            S_SCAN:
            begin
                chk_vld_next = nbr_ok;
                if (first_reg)
                begin
                    if (cfg.radius == '0)
                        state_next = S_TAIL;
                    else
                    begin
                        first_next = 1'b0;
                        d_next     = RAD_W'(1);
                        sub_next   = 2'd0;
                        dw_next    = POS_W'(cfg.width);
                    end
                end
                else if (sub_reg == 2'd3)
                begin
                    if (d_reg == cfg.radius)
                        state_next = S_TAIL;
                    else
                    begin
                        d_next   = d_reg + RAD_W'(1);
                        dw_next  = dw_reg + POS_W'(cfg.width);
                        sub_next = 2'd0;
                    end
                end
                else
                begin
                    sub_next = sub_reg + 2'd1;
                end
            end

            // The last read lands here.
            S_TAIL:
            begin
                state_next = S_EMIT;
            end

            // Load the output register, then advance the output position or rewind the positions at frame end.
            S_EMIT:
            begin
                if (emit_load)
                begin
                    out_valid_next = 1'b1;
                    out_col_next   = kept_reg ? colour_reg : COL_WHITE;
                    out_kept_next  = kept_reg;
                    out_last_next  = last_pix;
                    if (last_pix)
                    begin
                        out_pos_next   = '0;
                        in_pos_next    = '0;
                        out_haddr_next = '0;
                        in_haddr_next  = '0;
                        out_eaddr_next = '0;
                        in_eaddr_next  = '0;
                    end
                    else
                    begin
                        out_pos_next   = out_pos_inc[POS_W-1:0];
                        out_haddr_next = (out_haddr_reg == HIT_LAST) ? '0
                                       : out_haddr_reg + POS_W'(1);
                        out_eaddr_next = (out_eaddr_reg == EDGE_LAST) ? '0
                                       : out_eaddr_reg + POS_W'(1);
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_pos_reg    <= '0;
            out_pos_reg   <= '0;
            in_haddr_reg  <= '0;
            out_haddr_reg <= '0;
            in_eaddr_reg  <= '0;
            out_eaddr_reg <= '0;
            chk_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_pos_reg    <= in_pos_next;
            out_pos_reg   <= out_pos_next;
            in_haddr_reg  <= in_haddr_next;
            out_haddr_reg <= out_haddr_next;
            in_eaddr_reg  <= in_eaddr_next;
            out_eaddr_reg <= out_eaddr_next;
            chk_vld_reg   <= chk_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        hue_reg      <= hue_next;
        col_reg      <= col_next;
        own_reg      <= own_next;
        colour_reg   <= colour_next;
        lim_reg      <= lim_next;
        first_reg    <= first_next;
        d_reg        <= d_next;
        sub_reg      <= sub_next;
        dw_reg       <= dw_next;
        kept_reg     <= kept_next;
        out_col_reg  <= out_col_next;
        out_kept_reg <= out_kept_next;
        out_last_reg <= out_last_next;
    end

    // Output channel.
    assign pix_out.valid     = out_valid_reg;
    assign pix_out.out_blue  = out_col_reg[CH_W-1:0];
    assign pix_out.out_green = out_col_reg[2*CH_W-1:CH_W];
    assign pix_out.out_red   = out_col_reg[3*CH_W-1:2*CH_W];
    assign pix_out.out_kept  = out_kept_reg;
    assign pix_out.out_last  = out_last_reg;

    // Checks.
    `HMCD_ASSERT_IMP(a_pos_order, clk, rst_n, state_reg == S_IDLE, out_pos_reg <= in_pos_reg)
    `HMCD_ASSERT_NXT(a_chk_from_scan, clk, rst_n, state_reg != S_SCAN, !chk_vld_reg)
    `HMCD_ASSERT_NXT(a_emit_result, clk, rst_n, emit_load, out_valid_reg && state_reg == S_IDLE)
    `HMCD_ASSERT_IMP(a_addr_range, clk, rst_n, state_reg == S_IDLE, out_haddr_reg <= HIT_LAST && in_eaddr_reg <= EDGE_LAST)

endmodule
`default_nettype wire

// ----- hw/rtl/hue_mask_cross_dilate_unit.sv -----
`default_nettype none
// Channel   Direction  Payload
// pix_in    in         func, hue, edge_blue, edge_green, edge_red
// pix_out   out        out_blue, out_green, out_red, out_kept, out_last
// cfg       in         cfg_we, cfg_index, cfg_data (write only)
//
// A pixel item that emits a result is stored, scanned and loaded into the result register; the
// input is ready again as it is loaded. A pixel item with no result returns to idle from
// the decide state, a dropped pixel or a flush with nothing pending from the store state.
// The scan does one neighbour look-up per cycle on the single read port of the in-band
// bit memory. Reset clears the positions; the memories are not cleared.
// The next item is taken while a result waits in the output register; a stalled output
// holds a finished pixel back only when a second one is ready to be loaded.
module hue_mask_cross_dilate_unit #(
    parameter int MAX_WIDTH  = hmcd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = hmcd_pkg::MAX_RADIUS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [hmcd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hmcd_pkg::CFG_DATA_W-1:0] cfg_data,
    hmcd_in_if.sink                              pix_in,
    hmcd_out_if.source                           pix_out
);
    import hmcd_pkg::*;

    localparam int HIT_DEPTH  = 2 * MAX_RADIUS * MAX_WIDTH + 1;
    localparam int EDGE_DEPTH = MAX_RADIUS * MAX_WIDTH;

    hmcd_cfg_t        cfg;
    hmcd_mem_req_t    mem_req;
    logic             hit_rd;
    logic [COL_W-1:0] edge_rd;

    // Configuration registers and derived frame geometry.
    hmcd_cfg_regs #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // In-band bits and delayed colours.
    hmcd_stores #(
        .HIT_DEPTH  (HIT_DEPTH),
        .EDGE_DEPTH (EDGE_DEPTH)
    ) u_stores (
        .clk     (clk),
        .mem_req (mem_req),
        .hit_rd  (hit_rd),
        .edge_rd (edge_rd)
    );

    // Sequencer with the shared neighbour unit.
    hmcd_seq #(
        .HIT_DEPTH  (HIT_DEPTH),
        .EDGE_DEPTH (EDGE_DEPTH)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in),
        .pix_out (pix_out),
        .cfg     (cfg),
        .mem_req (mem_req),
        .hit_rd  (hit_rd),
        .edge_rd (edge_rd)
    );

endmodule
`default_nettype wire

// ----- test/hue_mask_cross_dilate_unit_test.sv -----
`timescale 1ns / 100ps
`default_nettype none
module hue_mask_cross_dilate_unit_test;
    import hmcd_pkg::*;

    localparam int HIT_DEPTH   = 2 * MAX_RADIUS_DEF * MAX_WIDTH_DEF + 1;
    localparam int EDGE_DEPTH  = MAX_RADIUS_DEF * MAX_WIDTH_DEF;
    localparam int ITEM_TARGET = 970;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 100;
    localparam int SHOWN_FAULTS = 10;

    // One transfer into the block and one out of it.
    typedef struct packed {
        logic             func;
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  blue;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  red;
    } pix_item_t;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
        logic            kept;
        logic            is_last;
    } pix_result_t;

    // Mask predictor with its own copy of the registers, stores and positions.
    class mask_scoreboard;
        bit               hit_mem [HIT_DEPTH];
        logic [COL_W-1:0] edge_mem [EDGE_DEPTH];
        int unsigned      in_pos;
        int unsigned      out_pos;
        logic [WID_W-1:0] width_reg;
        logic [WID_W-1:0] height_reg;
        logic [RAD_W-1:0] radius_reg;
        logic [HUE_W-1:0] hue_lo;
        logic [HUE_W-1:0] hue_hi;
        pix_result_t      expected_pixels [$];
        int               results_checked;
        int               fault_count;

        function void reset_state();
            width_reg       = FRAME_WIDTH_RST;
            height_reg      = FRAME_HEIGHT_RST;
            radius_reg      = RADIUS_RST;
            hue_lo          = HUE_LOW_RST;
            hue_hi          = HUE_HIGH_RST;
            in_pos          = 0;
            out_pos         = 0;
            results_checked = 0;
            fault_count     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_FRAME_WIDTH:  width_reg  = data[WID_W-1:0];
                REG_FRAME_HEIGHT: height_reg = data[WID_W-1:0];
                REG_RADIUS:       radius_reg = data[RAD_W-1:0];
                REG_HUE_LOW:      hue_lo     = data[HUE_W-1:0];
                REG_HUE_HIGH:     hue_hi     = data[HUE_W-1:0];
                default: ;
            endcase
        endfunction

        // Registers as the block uses them, clamped to the supported range.
        function int unsigned row_len();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
            return width_reg;
        endfunction

        function int unsigned row_count();
            if (height_reg == 0) return 1;
            if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
            return height_reg;
        endfunction

        function int unsigned reach();
            return (radius_reg > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : radius_reg;
        endfunction

        // True when the pixel or one on its cross, within the received extent, is in band.
        function bit near_band(int unsigned p, int unsigned lim, int unsigned w,
                               int unsigned r);
            int unsigned dw;
            if (hit_mem[p % HIT_DEPTH]) return 1;
            for (int unsigned d = 1; d <= r; d++) begin
                dw = d * w;
                if (p >= d && hit_mem[(p - d) % HIT_DEPTH]) return 1;
                if (p + d < lim && hit_mem[(p + d) % HIT_DEPTH]) return 1;
                if (p >= dw && hit_mem[(p - dw) % HIT_DEPTH]) return 1;
                if (p + dw < lim && hit_mem[(p + dw) % HIT_DEPTH]) return 1;
            end
            return 0;
        endfunction

        // Emits the pixel at the output position; the end of a frame rewinds both positions.
        function void release_pixel(logic [COL_W-1:0] colour, int unsigned total);
            int unsigned lim;
            int unsigned p;
            bit          kept;
            pix_result_t res;
            lim = (in_pos < total) ? in_pos : total;
            p = out_pos;
            kept = near_band(p, lim, row_len(), reach());
            {res.red, res.green, res.blue} = kept ? colour : COL_WHITE;
            res.kept = kept;
            res.is_last = (p + 1 >= total);
            expected_pixels.push_back(res);
            out_pos = p + 1;
            if (out_pos >= total) begin
                out_pos = 0;
                in_pos = 0;
            end
        endfunction

        function void note_item(pix_item_t it);
            int unsigned      w;
            int unsigned      total;
            int unsigned      rw;
            int unsigned      q;
            logic [COL_W-1:0] colour;
            logic [COL_W-1:0] delayed;
            w = row_len();
            total = w * row_count();
            rw = reach() * w;
            if (it.func == FUNC_FLUSH) begin
                if (out_pos < in_pos) release_pixel(edge_mem[out_pos % EDGE_DEPTH], total);
                return;
            end
            q = in_pos;
            // A pixel arriving once the frame is complete is dropped.
            if (q >= total) return;
            colour = {it.red, it.green, it.blue};
            delayed = (out_pos == q) ? colour : edge_mem[out_pos % EDGE_DEPTH];
            edge_mem[q % EDGE_DEPTH] = colour;
            hit_mem[q % HIT_DEPTH] = (it.hue >= hue_lo && it.hue <= hue_hi);
            in_pos = q + 1;
            if (out_pos < in_pos && (out_pos + rw < in_pos || in_pos >= total))
                release_pixel(delayed, total);
        endfunction

        function void check_pixel(pix_result_t got);
            pix_result_t want;
            results_checked++;
            if (expected_pixels.size() == 0) begin
                fault_count++;
                if (fault_count <= SHOWN_FAULTS)
                    $display("Unexpected pixel: b=%0d g=%0d r=%0d kept=%0b last=%0b",
                             got.blue, got.green, got.red, got.kept, got.is_last);
                return;
            end
            want = expected_pixels.pop_front();
            if (got.blue !== want.blue || got.green !== want.green || got.red !== want.red
                || got.kept !== want.kept || got.is_last !== want.is_last) begin
                fault_count++;
                if (fault_count <= SHOWN_FAULTS)
                    $display("Pixel %0d wrong: expected b=%0d g=%0d r=%0d kept=%0b last=%0b,%s",
                             results_checked, want.blue, want.green, want.red, want.kept,
                             want.is_last, "");
                if (fault_count <= SHOWN_FAULTS)
                    $display("    actual b=%0d g=%0d r=%0d kept=%0b last=%0b",
                             got.blue, got.green, got.red, got.kept, got.is_last);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    hmcd_in_if  pix_in ();
    hmcd_out_if pix_out ();

    hue_mask_cross_dilate_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_in    (pix_in),
        .pix_out   (pix_out)
    );

    mask_scoreboard sb;
    bit tx_calm;
    bit rx_calm;
    bit hold_req;
    int pixels_sent;
    int flushes_sent;
    int settings_used;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(20, 90);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [COL_W-1:0] rand_colour();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return COL_WHITE;
            default: return v[COL_W-1:0];
        endcase
    endfunction

    // Hues that land in the band often enough for the dilation to matter.
    function automatic logic [HUE_W-1:0] band_hue();
        if (sb.hue_lo <= sb.hue_hi && $urandom_range(0, 4) == 0)
            return $urandom_range(sb.hue_hi, sb.hue_lo);
        return $urandom_range(0, 255);
    endfunction

    // Offers one item and waits for its transfer.
    task automatic send_item(input pix_item_t it);
        int gap;
        gap = 0;
        if (!tx_calm && $urandom_range(0, 2) == 0) gap = gap_len();
        if (gap > 0)
        begin
            pix_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_in.valid      <= 1'b1;
        pix_in.func       <= it.func;
        pix_in.hue        <= it.hue;
        pix_in.edge_blue  <= it.blue;
        pix_in.edge_green <= it.green;
        pix_in.edge_red   <= it.red;
        @(posedge clk);
        while (!pix_in.ready) @(posedge clk);
        sb.note_item(it);
        if (it.func == FUNC_FLUSH) flushes_sent++;
        else pixels_sent++;
    endtask

    task automatic send_pixel(input logic [HUE_W-1:0] hue, input logic [COL_W-1:0] colour);
        pix_item_t it;
        it.func = FUNC_PIXEL;
        it.hue = hue;
        {it.red, it.green, it.blue} = colour;
        send_item(it);
    endtask

    // The payload of a flush is ignored, so it carries noise.
    task automatic send_flush();
        pix_item_t it;
        it.func = FUNC_FLUSH;
        it.hue = $urandom_range(0, 255);
        {it.red, it.green, it.blue} = rand_colour();
        send_item(it);
    endtask

    task automatic wait_drained();
        pix_in.valid <= 1'b0;
        do @(posedge clk); while (sb.expected_pixels.size() != 0);
    endtask

    // Idle point: every result back, then time for an item without a result to finish.
    task automatic settle();
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        sb.write_reg(idx, value[CFG_DATA_W-1:0]);
    endtask

    task automatic configure(input int w, input int h, input int r, input int lo,
                             input int hi);
        put_reg(REG_FRAME_WIDTH, w);
        put_reg(REG_FRAME_HEIGHT, h);
        put_reg(REG_RADIUS, r);
        put_reg(REG_HUE_LOW, lo);
        put_reg(REG_HUE_HIGH, hi);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Result side: checks each transfer and throttles ready.
    initial
    begin
        int rx_wait;
        pix_result_t got;
        rx_wait = 0;
        pix_out.ready <= 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (pix_out.valid && pix_out.ready)
            begin
                got.blue    = pix_out.out_blue;
                got.green   = pix_out.out_green;
                got.red     = pix_out.out_red;
                got.kept    = pix_out.out_kept;
                got.is_last = pix_out.out_last;
                sb.check_pixel(got);
            end
            if (hold_req)
            begin
                hold_req = 1'b0;
                rx_wait = HOLD_CYCLES;
            end
            if (rx_wait > 0)
            begin
                pix_out.ready <= 1'b0;
                rx_wait--;
            end
            else
            begin
                pix_out.ready <= 1'b1;
                if (!rx_calm && $urandom_range(0, 3) == 0) rx_wait = gap_len();
            end
        end
    end

    // Watchdog on cycles without any transfer.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) quiet = 0;
            else quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int w;
        int h;
        int r;
        int lo;
        int hi;
        int total;
        int pause_at;
        int frame_no;

        sb = new();
        sb.reset_state();
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        hold_req = 1'b0;
        pixels_sent = 0;
        flushes_sent = 0;
        settings_used = 0;
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= '0;
        cfg_data          <= '0;
        pix_in.valid      <= 1'b0;
        pix_in.func       <= FUNC_PIXEL;
        pix_in.hue        <= '0;
        pix_in.edge_blue  <= '0;
        pix_in.edge_green <= '0;
        pix_in.edge_red   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers at their reset values: radius zero, so each pixel comes straight back.
        send_pixel(8'd0, 24'h123456);
        send_pixel(8'd21, 24'hABCDEF);
        settle();
        // Shrinking the frame mid-way makes the next pixel the final one.
        put_reg(REG_FRAME_WIDTH, 1);
        put_reg(REG_FRAME_HEIGHT, 3);
        cfg_we <= 1'b0;
        send_pixel(8'd20, 24'h000000);

        // Out-of-range registers clamp: width to one, height and radius to their limits.
        settle();
        configure(0, 2047, 31, 255, 255);
        send_pixel(8'd255, 24'hFFFFFF);
        send_pixel(8'd254, 24'h00FF00);
        send_pixel(8'd0, 24'h0000FF);
        // The fourth flush finds nothing pending.
        repeat (4) send_flush();
        settle();
        put_reg(REG_FRAME_HEIGHT, 4);
        cfg_we <= 1'b0;
        send_pixel(8'd128, 24'hFF0000);

        // Empty band, then a pixel after the frame is complete, then the drain.
        settle();
        configure(2, 2, 1, 200, 100);
        send_pixel(8'd150, 24'h010203);
        send_pixel(8'd0, 24'h040506);
        send_pixel(8'd255, 24'h070809);
        send_pixel(8'd100, 24'h0A0B0C);
        send_pixel(8'd200, 24'h0D0E0F);
        repeat (3) send_flush();

        // Widest row; a flushed pixel sees only what has been received.
        settle();
        configure(1024, 1, 1, 0, 0);
        send_pixel(8'd0, 24'h55AA55);
        send_flush();
        settle();
        put_reg(REG_FRAME_WIDTH, 2);
        cfg_we <= 1'b0;
        send_pixel(8'd1, 24'hAA55AA);

        // Random frames, each under a fresh setting and drained by flushes.
        frame_no = 0;
        while (pixels_sent + flushes_sent < ITEM_TARGET)
        begin
            settle();
            case ($urandom_range(0, 5))
                0: begin w = 1; h = $urandom_range(10, 40); end
                1: begin w = $urandom_range(16, 40); h = $urandom_range(1, 2); end
                default: begin w = $urandom_range(0, 12); h = $urandom_range(0, 8); end
            endcase
            if ($urandom_range(0, 9) == 0) r = $urandom_range(21, 31);
            else if ($urandom_range(0, 1) == 0) r = $urandom_range(0, 3);
            else r = $urandom_range(0, 20);
            case ($urandom_range(0, 4))
                0: begin lo = 0; hi = 255; end
                1: begin lo = $urandom_range(1, 255); hi = $urandom_range(0, lo - 1); end
                default:
                begin
                    lo = $urandom_range(0, 255);
                    hi = lo + $urandom_range(0, 60);
                    if (hi > 255) hi = 255;
                end
            endcase
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            // One frame where the output stalls long enough to back up the input.
            if (frame_no == 2)
            begin
                w = 8;
                h = 6;
                r = 0;
                tx_calm = 1'b1;
            end
            configure(w, h, r, lo, hi);
            if (frame_no == 2) hold_req = 1'b1;
            total = sb.row_len() * sb.row_count();
            pause_at = -1;
            if (frame_no == 1 || $urandom_range(0, 7) == 0)
                pause_at = $urandom_range(0, total - 1);
            for (int i = 0; i < total; i++)
            begin
                if (i == pause_at) wait_drained();
                if ($urandom_range(0, 15) == 0) send_flush();
                send_pixel(band_hue(), rand_colour());
            end
            // A stray pixel while the frame is still draining is dropped.
            if (sb.in_pos != 0 && $urandom_range(0, 3) == 0)
                send_pixel(band_hue(), rand_colour());
            while (sb.in_pos != 0) send_flush();
            if ($urandom_range(0, 3) == 0) send_flush();
            frame_no++;
        end

        tx_calm = 1'b1;
        settle();
        $display("Run covered %0d pixel and %0d flush transfers under %0d register settings,",
                 pixels_sent, flushes_sent, settings_used);
        $display("with %0d results checked and %0d faults found.",
                 sb.results_checked, sb.fault_count);
        if (sb.fault_count == 0 && sb.expected_pixels.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire
